// File: rtl/bcv_pkg.sv
// ----------------------------------------------------------------------------
// Battery charge from voltage: shared package
// Item types, the lithium-ion open-circuit voltage curve and table lookups
// used by the pipeline stages.
// ----------------------------------------------------------------------------
package bcv_pkg;

  localparam int unsigned CURVE_POINTS = 12;
  localparam int unsigned SEGMENTS     = CURVE_POINTS - 1;
  localparam int unsigned SIX_CELLS    = 6;
  localparam int unsigned FOUR_CELLS   = 4;
  localparam logic [2:0]  CELLS_RESET  = 3'd4;
  localparam logic [2:0]  CELLS_SIX    = 3'd6;
  localparam int unsigned PRESENT_MIN  = 500;
  localparam int unsigned RECIP_SHIFT  = 24;
  localparam logic [9:0]  CHARGE_NONE  = 10'd0;

  // Per-cell curve in millivolts and the matching charge in per-mille.
  localparam int unsigned CURVE_MV [CURVE_POINTS] = '{
    3000, 3300, 3500, 3620, 3700, 3770, 3830, 3870, 3920, 3980, 4060, 4200
  };
  localparam int unsigned CURVE_PM [CURVE_POINTS] = '{
    0, 50, 100, 200, 300, 400, 500, 600, 700, 800, 900, 1000
  };

  // floor(2^24 / span) for each segment, span scaled by the cell count.
  localparam int unsigned RECIP4 [SEGMENTS] = '{
    (1 << RECIP_SHIFT) / (300 * FOUR_CELLS), (1 << RECIP_SHIFT) / (200 * FOUR_CELLS),
    (1 << RECIP_SHIFT) / (120 * FOUR_CELLS), (1 << RECIP_SHIFT) / (80 * FOUR_CELLS),
    (1 << RECIP_SHIFT) / (70 * FOUR_CELLS),  (1 << RECIP_SHIFT) / (60 * FOUR_CELLS),
    (1 << RECIP_SHIFT) / (40 * FOUR_CELLS),  (1 << RECIP_SHIFT) / (50 * FOUR_CELLS),
    (1 << RECIP_SHIFT) / (60 * FOUR_CELLS),  (1 << RECIP_SHIFT) / (80 * FOUR_CELLS),
    (1 << RECIP_SHIFT) / (140 * FOUR_CELLS)
  };
  localparam int unsigned RECIP6 [SEGMENTS] = '{
    (1 << RECIP_SHIFT) / (300 * SIX_CELLS), (1 << RECIP_SHIFT) / (200 * SIX_CELLS),
    (1 << RECIP_SHIFT) / (120 * SIX_CELLS), (1 << RECIP_SHIFT) / (80 * SIX_CELLS),
    (1 << RECIP_SHIFT) / (70 * SIX_CELLS),  (1 << RECIP_SHIFT) / (60 * SIX_CELLS),
    (1 << RECIP_SHIFT) / (40 * SIX_CELLS),  (1 << RECIP_SHIFT) / (50 * SIX_CELLS),
    (1 << RECIP_SHIFT) / (60 * SIX_CELLS),  (1 << RECIP_SHIFT) / (80 * SIX_CELLS),
    (1 << RECIP_SHIFT) / (140 * SIX_CELLS)
  };

  typedef struct packed {
    logic [15:0] pack_millivolts;
    logic        voltage_ok;
    logic        current_ok;
    logic [9:0]  presence_level;
  } sample_t;

  typedef struct packed {
    logic [9:0] charge_permille;
    logic       charge_valid;
    logic       battery_present;
    logic       supply_status;
    logic       supply_health;
  } result_t;

  // After the segment search.
  typedef struct packed {
    logic [3:0]  seg;
    logic        six;
    logic [9:0]  base;
    logic [6:0]  rise;
    logic [10:0] offset;
    logic        ok;
    logic        present;
  } seg_item_t;

  // After offset * rise.
  typedef struct packed {
    logic [17:0] prod;
    logic [10:0] span;
    logic [16:0] recip;
    logic [9:0]  base;
    logic        ok;
    logic        present;
  } mul_item_t;

  // After the reciprocal estimate of the quotient.
  typedef struct packed {
    logic [17:0] prod;
    logic [10:0] span;
    logic [6:0]  quo;
    logic [9:0]  base;
    logic        ok;
    logic        present;
  } quo_item_t;

  // After the remainder of the estimate.
  typedef struct packed {
    logic [17:0] rem;
    logic [10:0] span;
    logic [6:0]  quo;
    logic [9:0]  base;
    logic        ok;
    logic        present;
  } rem_item_t;

  function automatic logic [15:0] point_mv(input logic [3:0] idx, input logic six);
    logic [15:0] mv;
    mv = 16'd0;
    if (idx < 4'(CURVE_POINTS)) begin
      mv = six ? 16'(CURVE_MV[idx] * SIX_CELLS) : 16'(CURVE_MV[idx] * FOUR_CELLS);
    end
    return mv;
  endfunction

  function automatic logic [9:0] point_pm(input logic [3:0] idx);
    logic [9:0] pm;
    pm = 10'd0;
    if (idx < 4'(CURVE_POINTS)) begin
      pm = 10'(CURVE_PM[idx]);
    end
    return pm;
  endfunction

  function automatic logic [10:0] seg_span(input logic [3:0] seg, input logic six);
    return 11'(point_mv(4'(seg + 4'd1), six) - point_mv(seg, six));
  endfunction

  function automatic logic [16:0] seg_recip(input logic [3:0] seg, input logic six);
    logic [16:0] r;
    r = 17'd1;
    if (seg < 4'(SEGMENTS)) begin
      r = six ? 17'(RECIP6[seg]) : 17'(RECIP4[seg]);
    end
    return r;
  endfunction

endpackage

// File: rtl/battery_charge_from_voltage_core.sv
// ----------------------------------------------------------------------------
// Battery charge from voltage: top level
// Lithium-ion state of charge from pack voltage over a 12-point curve.
// ----------------------------------------------------------------------------
// An accepted item passes the segment, product, estimate, remainder and result registers in order.
// Throughput: one item per cycle while the output is not stalled; each of the five stages holds one item.
// Reset (rst, synchronous, active high) empties the pipeline and sets the
// cell count register to four cells.
// ----------------------------------------------------------------------------
module battery_charge_from_voltage_core import bcv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  input  logic       sample_valid,
  output logic       sample_stall,
  input  sample_t    sample,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result
);

  // The cell count register; only six selects six cells, others act as four.
  // The user writes it only while the pipeline is empty; it is not enforced.
  logic [2:0] cells_in_series;

  // Stage handshakes. Each stage is ready when it is empty or when the stage
  // after it moves, so bubbles close up and the input keeps taking items
  // while a finished result waits on the output, until every stage holds an item.
  logic      seg_ready;
  logic      seg_valid;
  seg_item_t seg_item;
  logic      div_ready;
  logic      rem_valid;
  rem_item_t rem_item;
  logic      out_ready;

  logic [6:0] quo_fixed;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_in_series <= CELLS_RESET;
    end else if (cfg_we) begin
      cells_in_series <= cfg_wdata;
    end
  end

  assign sample_stall = !seg_ready;

  // Stage 1: pick the curve segment and the offset of the pack voltage in it.
  bcv_seg u_seg (
    .clk      (clk),
    .rst      (rst),
    .six      (cells_in_series == CELLS_SIX),
    .up_valid (sample_valid),
    .up_ready (seg_ready),
    .up_item  (sample),
    .dn_valid (seg_valid),
    .dn_ready (div_ready),
    .dn_item  (seg_item)
  );

  // Stages 2 to 4: offset times rise, reciprocal quotient estimate, remainder.
  bcv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (seg_valid),
    .up_ready (div_ready),
    .up_item  (seg_item),
    .dn_valid (rem_valid),
    .dn_ready (out_ready),
    .dn_item  (rem_item)
  );

  // Stage 5: the estimate is at most one low, so a single compare of the
  // remainder against the span finishes the floor division. Invalid
  // readings force the charge to zero and both status flags to unknown.
  assign out_ready = !result_valid || !result_stall;
  assign quo_fixed = (rem_item.rem >= 18'(rem_item.span)) ?
                     7'(rem_item.quo + 7'd1) : rem_item.quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= rem_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && rem_valid) begin
      result.charge_permille <= rem_item.ok ? 10'(rem_item.base + 10'(quo_fixed))
                                            : CHARGE_NONE;
      result.charge_valid    <= rem_item.ok;
      result.battery_present <= rem_item.present;
      result.supply_status   <= !rem_item.ok;
      result.supply_health   <= !rem_item.ok;
    end
  end

endmodule

// File: rtl/bcv_seg.sv
// ----------------------------------------------------------------------------
// Battery charge from voltage: segment search stage
// Finds the curve segment of the pack voltage and the offset into it.
// ----------------------------------------------------------------------------
module bcv_seg import bcv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      six,
  input  logic      up_valid,
  output logic      up_ready,
  input  sample_t   up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output seg_item_t dn_item
);

  seg_item_t item_next;
  logic [3:0] seg;
  logic       sat_lo;
  logic       sat_hi;
  logic [15:0] pack;
  logic [15:0] lo_mv;

  assign up_ready = !dn_valid || dn_ready;
  assign pack     = up_item.pack_millivolts;

  always_comb begin
    sat_lo = pack <= point_mv(4'd0, six);
    sat_hi = pack >= point_mv(4'(CURVE_POINTS - 1), six);
    seg    = 4'd0;
    // Highest point first so the lowest matching point wins.
    for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
      if (pack <= point_mv(4'(i), six)) begin
        seg = 4'(i - 1);
      end
    end
    lo_mv = point_mv(seg, six);

    item_next.seg     = seg;
    item_next.six     = six;
    item_next.ok      = up_item.voltage_ok && up_item.current_ok;
    item_next.present = up_item.presence_level > 10'(PRESENT_MIN);
    if (sat_lo || sat_hi) begin
      item_next.base   = sat_hi ? point_pm(4'(CURVE_POINTS - 1)) : point_pm(4'd0);
      item_next.rise   = 7'd0;
      item_next.offset = 11'd0;
    end else begin
      item_next.base   = point_pm(seg);
      item_next.rise   = 7'(point_pm(4'(seg + 4'd1)) - point_pm(seg));
      item_next.offset = 11'(pack - lo_mv);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= item_next;
    end
  end

endmodule

// File: rtl/bcv_div.sv
// ----------------------------------------------------------------------------
// Battery charge from voltage: scale and divide stages
// Multiplies the offset by the segment rise, then divides by the segment
// span through a reciprocal estimate and its remainder.
// ----------------------------------------------------------------------------
module bcv_div import bcv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  seg_item_t up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output rem_item_t dn_item
);

  logic      mul_valid;
  logic      mul_ready;
  mul_item_t mul_item;
  logic      quo_valid;
  logic      quo_ready;
  quo_item_t quo_item;
  logic      rem_ready;

  logic [34:0] est;
  logic [17:0] back;

  assign rem_ready = !dn_valid || dn_ready;
  assign quo_ready = !quo_valid || rem_ready;
  assign mul_ready = !mul_valid || quo_ready;
  assign up_ready  = mul_ready;

  assign est  = 35'(mul_item.prod) * 35'(mul_item.recip);
  assign back = 18'(quo_item.quo) * 18'(quo_item.span);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      quo_valid <= 1'b0;
      dn_valid  <= 1'b0;
    end else begin
      if (mul_ready) mul_valid <= up_valid;
      if (quo_ready) quo_valid <= mul_valid;
      if (rem_ready) dn_valid  <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && up_valid) begin
      mul_item.prod    <= 18'(up_item.offset) * 18'(up_item.rise);
      mul_item.span    <= seg_span(up_item.seg, up_item.six);
      mul_item.recip   <= seg_recip(up_item.seg, up_item.six);
      mul_item.base    <= up_item.base;
      mul_item.ok      <= up_item.ok;
      mul_item.present <= up_item.present;
    end
    if (quo_ready && mul_valid) begin
      quo_item.prod    <= mul_item.prod;
      quo_item.span    <= mul_item.span;
      quo_item.quo     <= est[RECIP_SHIFT +: 7];
      quo_item.base    <= mul_item.base;
      quo_item.ok      <= mul_item.ok;
      quo_item.present <= mul_item.present;
    end
    if (rem_ready && quo_valid) begin
      dn_item.rem     <= quo_item.prod - back;
      dn_item.span    <= quo_item.span;
      dn_item.quo     <= quo_item.quo;
      dn_item.base    <= quo_item.base;
      dn_item.ok      <= quo_item.ok;
      dn_item.present <= quo_item.present;
    end
  end

endmodule

// File: rtl/bcv_checker.sv
// ----------------------------------------------------------------------------
// Battery charge from voltage: port checker
// Watches the top level's ports for output handshake and result sanity.
// ----------------------------------------------------------------------------
module bcv_checker import bcv_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // A stalled result stays on the output unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // An invalid reading carries zero charge and unknown status and health.
  a_invalid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.charge_valid |->
      result.charge_permille == CHARGE_NONE && result.supply_status &&
      result.supply_health)
    else $error("invalid reading with wrong fields");

  // The charge never leaves the per-mille range and status follows validity.
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.charge_permille <= 10'd1000 &&
      result.supply_status == !result.charge_valid)
    else $error("charge out of range or status mismatch");

endmodule

bind battery_charge_from_voltage_core bcv_checker u_bcv_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
